// ===== rtl/core/alignment_chunks_to_genomic_intervals_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the alignment chunk to genomic interval unit
// Concurrent property wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ALIGNMENT_CHUNKS_TO_GENOMIC_INTERVALS_UNIT_ASSERT_SVH
`define ALIGNMENT_CHUNKS_TO_GENOMIC_INTERVALS_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define ACTGI_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("property violated");

// next-cycle implication, disabled while the given condition is high
`define ACTGI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("property violated");

`endif

// ===== rtl/core/actgi_pkg.sv =====
// ----------------------------------------------------------------------------
// actgi_pkg
// Types and constants shared by the alignment chunk to interval unit.
// ----------------------------------------------------------------------------
package actgi_pkg;

   // operation codes
   localparam logic [2:0] OP_MATCH       = 3'd0;
   localparam logic [2:0] OP_MISMATCH    = 3'd1;
   localparam logic [2:0] OP_DIAG        = 3'd2;
   localparam logic [2:0] OP_GENOMIC_INS = 3'd3;
   localparam logic [2:0] OP_PRODUCT_INS = 3'd4;

   // result queue sizing
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [2:0]  op;
      logic [23:0] op_length;
      logic [31:0] exon_start;
      logic [31:0] exon_end;
      logic        minus_strand;
      logic        last_chunk;
   } actgi_req_type;

   typedef struct packed {
      logic [31:0] interval_from;
      logic [31:0] interval_to;
      logic        has_interval;
      logic        exon_done;
   } actgi_rsp_type;

   // running chunk state of the current exon
   typedef struct packed {
      logic [31:0] open_transcribed;
      logic [31:0] open_span;
      logic [31:0] span_before;
      logic        prev_was_diag;
      logic        chunk_open;
   } actgi_state_type;

   // results produced by one request, in delivery order
   typedef struct packed {
      logic [1:0]    count;
      actgi_rsp_type slot0;
      actgi_rsp_type slot1;
   } actgi_push_type;

   typedef struct packed {
      actgi_push_type  push;
      actgi_state_type next_state;
   } actgi_step_type;

endpackage

// ===== rtl/core/actgi_if.sv =====
// ----------------------------------------------------------------------------
// actgi request and response channels
// Valid/ready channel interfaces for the interval unit.
// ----------------------------------------------------------------------------
interface actgi_req_if import actgi_pkg::*; ();
   logic          valid;
   logic          ready;
   actgi_req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface actgi_rsp_if import actgi_pkg::*; ();
   logic          valid;
   logic          ready;
   actgi_rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/alignment_chunks_to_genomic_intervals_unit.sv =====
// ----------------------------------------------------------------------------
// alignment_chunks_to_genomic_intervals_unit
// Turns one exon's alignment operations into genomic intervals.
// ----------------------------------------------------------------------------
// Each request is one alignment operation of an exon; the unit merges
// diagonal runs into chunks, folds gaps into the open chunk and returns each
// chunk with nonzero transcribed length as a genomic interval offset from the
// exon start (plus strand) or end (minus strand). A request is taken every
// cycle while the four-entry result queue has two free slots; a request is
// registered in the input stage register, processed from there once the queue
// has two free slots, and its results are written into the queue. A request
// can produce two results, and the response channel drains one per cycle
// while ready is high, so streams with many chunk closes at exon ends are
// limited by the response port.
module alignment_chunks_to_genomic_intervals_unit import actgi_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   actgi_req_if.sink    req_chan,
   actgi_rsp_if.source  rsp_chan
);

   logic            stage_valid_ff;
   logic            stage_valid_in;
   actgi_req_type   stage_data_ff;
   actgi_state_type state_ff;
   actgi_state_type state_in;
   actgi_step_type  step;
   actgi_push_type  push;
   logic            room;
   logic            advance;
   logic            req_take;

   // input register handshake
   assign advance        = stage_valid_ff && room;
   assign req_chan.ready = !stage_valid_ff || room;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign stage_valid_in = req_take || (stage_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_data_ff <= req_chan.data;
      end
   end

   // chunk logic
   actgi_step u_step (
      .state (state_ff),
      .item  (stage_data_ff),
      .step  (step)
   );

   // chunk state update
   assign state_in = advance ? step.next_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   // results into the queue
   always_comb begin
      push       = step.push;
      push.count = advance ? step.push.count : 2'd0;
   end

   actgi_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== rtl/core/actgi_step.sv =====
// ----------------------------------------------------------------------------
// actgi_step
// Next chunk state and up to two result entries for one request.
// ----------------------------------------------------------------------------
module actgi_step import actgi_pkg::*; (
   input  actgi_state_type state,
   input  actgi_req_type   item,
   output actgi_step_type  step
);

   // interval for a chunk at offset span from the strand origin
   function automatic actgi_rsp_type make_interval(
      input logic [31:0] start,
      input logic [31:0] stop,
      input logic        minus,
      input logic [31:0] span,
      input logic [31:0] tlen,
      input logic        done
   );
      actgi_rsp_type r;
      logic [31:0]   near;
      logic [31:0]   far;
      r.has_interval = 1'b1;
      r.exon_done    = done;
      if (minus) begin
         near            = stop - span;
         far             = near - (tlen - 32'd1);
         r.interval_from = far;
         r.interval_to   = near;
      end else begin
         near            = start + span;
         far             = near + (tlen - 32'd1);
         r.interval_from = near;
         r.interval_to   = far;
      end
      return r;
   endfunction

   logic            diag;
   logic            extend;
   logic            emit_closed;
   logic            emit_final;
   logic [31:0]     len;
   actgi_state_type upd;
   actgi_rsp_type   closed_rsp;
   actgi_rsp_type   final_rsp;

   assign len  = {8'd0, item.op_length};
   assign diag = item.op inside {[OP_MATCH:OP_DIAG]};

   // chunk bookkeeping
   always_comb begin
      upd         = state;
      extend      = state.prev_was_diag && state.chunk_open;
      emit_closed = 1'b0;
      if (diag) begin
         if (extend) begin
            upd.open_transcribed = state.open_transcribed + len;
            upd.open_span        = state.open_span + len;
         end else begin
            if (state.chunk_open) begin
               emit_closed     = (state.open_transcribed != 32'd0);
               upd.span_before = state.span_before + state.open_span;
            end
            upd.open_transcribed = len;
            upd.open_span        = len;
            upd.chunk_open       = 1'b1;
         end
      end else begin
         if (!state.chunk_open) begin
            upd.open_transcribed = 32'd0;
            upd.open_span        = 32'd0;
            upd.chunk_open       = 1'b1;
         end
         case (item.op)
            OP_PRODUCT_INS: upd.open_transcribed = upd.open_transcribed + len;
            OP_GENOMIC_INS: upd.open_span        = upd.open_span + len;
            default:        upd.open_span        = upd.open_span;
         endcase
      end
      upd.prev_was_diag = diag;
   end

   // closed chunk uses the state before this request
   assign closed_rsp = make_interval(item.exon_start, item.exon_end, item.minus_strand,
                                     state.span_before, state.open_transcribed, 1'b0);

   // end of exon: open chunk as interval, or a bare end marker
   assign emit_final = upd.chunk_open && (upd.open_transcribed != 32'd0);
   always_comb begin
      if (emit_final) begin
         final_rsp = make_interval(item.exon_start, item.exon_end, item.minus_strand,
                                   upd.span_before, upd.open_transcribed, 1'b1);
      end else begin
         final_rsp = '{interval_from: 32'd0, interval_to: 32'd0,
                       has_interval: 1'b0, exon_done: 1'b1};
      end
   end

   // result ordering and state after the request
   always_comb begin
      step.push.count = {1'b0, emit_closed} + {1'b0, item.last_chunk};
      step.push.slot0 = emit_closed ? closed_rsp : final_rsp;
      step.push.slot1 = final_rsp;
      step.next_state = item.last_chunk ? '0 : upd;
   end

endmodule

// ===== rtl/core/actgi_rsp_fifo.sv =====
// ----------------------------------------------------------------------------
// actgi_rsp_fifo
// Small result queue taking up to two entries per cycle, one out per cycle.
// ----------------------------------------------------------------------------
module actgi_rsp_fifo import actgi_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  actgi_push_type push,
   output logic           room,
   actgi_rsp_if.source    rsp_chan
);

   actgi_rsp_type          mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff;
   logic [RSP_PTR_W-1:0]   wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff;
   logic [RSP_PTR_W-1:0]   rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff;
   logic [RSP_CNT_W-1:0]   count_in;
   logic                   pop;

   // output side
   assign rsp_chan.valid = (count_ff != '0);
   assign rsp_chan.data  = mem_ff[rd_ptr_ff];
   assign pop            = rsp_chan.valid && rsp_chan.ready;

   // two free entries needed, from registered fill only
   assign room = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));

   // pointer and fill tracking
   assign wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
   assign count_in  = count_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage writes
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.slot0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + RSP_PTR_W'(1)] <= push.slot1;
      end
   end

endmodule

// ===== rtl/core/actgi_checker.sv =====
// ----------------------------------------------------------------------------
// actgi_checker
// Port-level properties of the interval unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "alignment_chunks_to_genomic_intervals_unit_assert.svh"

module actgi_checker import actgi_pkg::*; (
   input logic          clock,
   input logic          reset,
   input logic          rsp_valid,
   input logic          rsp_ready,
   input actgi_rsp_type rsp_data
);

   // a waiting response holds
   `ACTGI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // a bare marker only ever closes an exon
   `ACTGI_ASSERT_NOW(a_bare_is_end, clock, reset, rsp_valid && !rsp_data.has_interval, rsp_data.exon_done)

   // a bare marker carries zero coordinates
   `ACTGI_ASSERT_NOW(a_bare_zero, clock, reset, rsp_valid && !rsp_data.has_interval, (rsp_data.interval_from == 32'd0) && (rsp_data.interval_to == 32'd0))

   // queue is empty after reset
   `ACTGI_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind alignment_chunks_to_genomic_intervals_unit actgi_checker u_actgi_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);
